// ===== design/dual_channel_moving_average_scaler_unit_assert.svh =====
// Assertion macros for the dual-channel moving-average scaler.
// Included by the top level; needs nothing else.
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_SCALER_UNIT_ASSERT_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DCMAS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcmas assertion failed");

// Next-cycle implication, held off during reset.
`define DCMAS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcmas assertion failed");

`endif

// ===== design/dcmas_pkg.sv =====
// Shared types and constants of the dual-channel moving-average scaler.
// Used by every module of the block but dcmas_ram; depends on nothing.
`default_nettype none

package dcmas_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SENSE_W     = 22;
    localparam int GAIN_W      = 12;
    localparam int SCALED_W    = 25;
    localparam int CFG_W       = 22;
    localparam int CFG_IDX_W   = 3;

    // Shared divider: 10-bit divisor, 36-bit dividend, four quotient bits a cycle.
    localparam int DIV_W       = 10;
    localparam int DVD_W       = 36;
    localparam int RADIX_BITS  = 4;
    localparam int STEP_W      = 4;
    localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(SAMPLE_BITS / RADIX_BITS);
    localparam logic [STEP_W-1:0] MILLI_STEPS = STEP_W'(DVD_W / RADIX_BITS);
    localparam logic [DIV_W-1:0]  MILLI_DIV   = DIV_W'(1000);

    localparam logic [SENSE_W-1:0] SENSE_FULL_UV = SENSE_W'(2500000);
    localparam logic [SENSE_W-1:0] SENSED_MAX    =
        SENSE_W'((longint'((1 << SAMPLE_BITS) - 1) * 64'd2500000) >> SAMPLE_BITS);

    localparam logic signed [SCALED_W-1:0] SCALED_MAX = 25'sh0FFFFFF;
    localparam logic signed [SCALED_W-1:0] SCALED_MIN = 25'sh1000000;
    localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'(16777215);
    localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(16777216);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_THRESHOLD     = 3'd0,
        CFG_VOLTAGE_GAIN      = 3'd1,
        CFG_VOLTAGE_OFFSET_UV = 3'd2,
        CFG_CURRENT_SCALE     = 3'd3,
        CFG_CURRENT_OFFSET_UV = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] led_threshold;
        logic [GAIN_W-1:0]      voltage_gain;
        logic [SENSE_W-1:0]     voltage_offset_uv;
        logic [GAIN_W-1:0]      current_scale;
        logic [SENSE_W-1:0]     current_offset_uv;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        led_threshold:     12'd1638,
        voltage_gain:      12'd772,
        voltage_offset_uv: 22'd1286000,
        current_scale:     12'd20,
        current_offset_uv: 22'd1650000
    };

    typedef struct packed {
        logic                   ch;
        logic [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DIV_W-1:0]   rem_init;
        logic [DIV_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_AVG,
        ST_SENSE,
        ST_DIFF,
        ST_MUL,
        ST_MILLI,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/dcmas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the sample windows; depends on nothing.
`default_nettype none

module dcmas_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 200
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/dcmas_div.sv =====
// Shared restoring divider, four quotient bits per cycle.
// Used for the window average and the milli-unit scaling; uses dcmas_pkg.
`default_nettype none

module dcmas_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dcmas_pkg::t_div_req        i_req,
    output logic                            o_done,
    output logic [dcmas_pkg::DVD_W-1:0]     o_quot
);

    logic [dcmas_pkg::DVD_W-1:0]  r_q;
    logic [dcmas_pkg::DIV_W-1:0]  r_rem;
    logic [dcmas_pkg::DIV_W-1:0]  r_div;
    logic [dcmas_pkg::STEP_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;

    logic [dcmas_pkg::DVD_W-1:0]  n_q;
    logic [dcmas_pkg::DIV_W-1:0]  n_rem;
    logic [dcmas_pkg::DIV_W:0]    t_wide;

    // The remainder stays below the divisor, so each step is a narrow compare and subtract.
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        t_wide = '0;
        for (int k = 0; k < dcmas_pkg::RADIX_BITS; k++) begin
            t_wide = {n_rem, n_q[dcmas_pkg::DVD_W-1]};
            n_q    = {n_q[dcmas_pkg::DVD_W-2:0], 1'b0};
            if (t_wide >= {1'b0, r_div}) begin
                t_wide = t_wide - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
            n_rem = t_wide[dcmas_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= i_req.rem_init;
            r_div <= i_req.divisor;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == dcmas_pkg::STEP_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== design/dcmas_front.sv =====
// Front end: accepts samples, tags each with the channel now due, and queues it.
// Two-entry queue toward the back end; uses dcmas_pkg.
`default_nettype none

module dcmas_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [dcmas_pkg::SAMPLE_BITS-1:0] i_sample,
    output dcmas_pkg::t_item                      o_item,
    output logic                                  o_item_valid,
    input  wire logic                             i_pop
);

    dcmas_pkg::t_item r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             r_due;
    logic             t_push;

    assign o_in_ready   = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_slot[r_rd_ptr];
    assign t_push       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (t_push) begin
            r_slot[r_wr_ptr] <= '{ch: r_due, sample: i_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_due    <= 1'b0;
        end else begin
            if (t_push) begin
                r_wr_ptr <= ~r_wr_ptr;
                r_due    <= ~r_due;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({t_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/dcmas_back.sv =====
// Back end: window update, average, sensed level, scaling and the result register.
// Uses dcmas_pkg, dcmas_ram for both windows and dcmas_div.
`default_nettype none

module dcmas_back #(
    parameter int WINDOW = 200
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire dcmas_pkg::t_cfg                         i_cfg,
    input  wire dcmas_pkg::t_item                        i_item,
    input  wire logic                                    i_item_valid,
    output logic                                         o_pop,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic                                         o_channel,
    output logic        [dcmas_pkg::SAMPLE_BITS-1:0]     o_average_code,
    output logic        [dcmas_pkg::SENSE_W-1:0]         o_sensed_uv,
    output logic signed [dcmas_pkg::SCALED_W-1:0]        o_scaled_milli,
    output logic                                         o_led_on
);

    localparam int SB    = dcmas_pkg::SAMPLE_BITS;
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SB + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int PRD_W = dcmas_pkg::GAIN_W + dcmas_pkg::SENSE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    dcmas_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]           r_idx    [2];
    logic                       r_filled [2];
    logic [SUM_W-1:0]           r_sum    [2];
    logic                       r_ch;
    logic [SB-1:0]              r_smp;
    logic [SB-1:0]              r_avg;
    logic [dcmas_pkg::SENSE_W-1:0] r_sensed;
    logic [dcmas_pkg::SENSE_W-1:0] r_mag;
    logic                       r_neg;
    logic                       r_ind;

    logic                       r_o_valid;
    logic                       r_o_ch;
    logic [SB-1:0]              r_o_avg;
    logic [dcmas_pkg::SENSE_W-1:0] r_o_sensed;
    logic signed [dcmas_pkg::SCALED_W-1:0] r_o_scaled;
    logic                       r_o_led;

    logic [1:0]                 t_we;
    logic [IDX_W-1:0]           t_raddr;
    logic [SB-1:0]              t_rd_volt;
    logic [SB-1:0]              t_rd_curr;
    logic [SB-1:0]              t_old;
    logic [SUM_W-1:0]           t_new_sum;
    logic                       t_wrap;
    logic                       t_full;
    logic [PRD_W-1:0]           t_sense_prod;
    logic [dcmas_pkg::SENSE_W-1:0] t_offset;
    logic [dcmas_pkg::GAIN_W-1:0]  t_gain;
    logic [PRD_W-1:0]           t_prod;
    logic signed [dcmas_pkg::SCALED_W-1:0] t_scaled;
    logic                       t_out_free;
    logic                       t_div_done;
    logic [dcmas_pkg::DVD_W-1:0] t_quot;
    dcmas_pkg::t_div_req        t_div_req;

    dcmas_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_ram_volt (
        .i_clk   (i_clk),
        .i_we    (t_we[0]),
        .i_waddr (r_idx[0]),
        .i_wdata (r_smp),
        .i_raddr (t_raddr),
        .o_rdata (t_rd_volt)
    );

    dcmas_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_ram_curr (
        .i_clk   (i_clk),
        .i_we    (t_we[1]),
        .i_waddr (r_idx[1]),
        .i_wdata (r_smp),
        .i_raddr (t_raddr),
        .o_rdata (t_rd_curr)
    );

    dcmas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (t_div_req),
        .o_done  (t_div_done),
        .o_quot  (t_quot)
    );

    // Entries are written in index order, so before the window has filled the
    // entry about to be replaced was never written and counts as zero.
    assign t_raddr   = r_idx[i_item.ch];
    assign t_old     = r_filled[r_ch] ? (r_ch ? t_rd_curr : t_rd_volt) : '0;
    assign t_new_sum = r_sum[r_ch] - SUM_W'(t_old) + SUM_W'(r_smp);
    assign t_wrap    = (r_idx[r_ch] == LAST_IDX);
    assign t_full    = r_filled[r_ch] || t_wrap;

    assign t_sense_prod = {{dcmas_pkg::SENSE_W{1'b0}}, r_avg}
                        * {{SB{1'b0}}, dcmas_pkg::SENSE_FULL_UV};
    assign t_offset = r_ch ? i_cfg.current_offset_uv : i_cfg.voltage_offset_uv;
    assign t_gain   = r_ch ? i_cfg.current_scale : i_cfg.voltage_gain;
    assign t_prod   = {{dcmas_pkg::SENSE_W{1'b0}}, t_gain}
                    * {{dcmas_pkg::GAIN_W{1'b0}}, r_mag};
    assign t_out_free = !r_o_valid || i_out_ready;

    // The quotient is a magnitude; the sign goes back on after saturation.
    always_comb begin
        if (!r_neg) begin
            t_scaled = (t_quot > dcmas_pkg::POS_LIMIT) ? dcmas_pkg::SCALED_MAX
                     : $signed(t_quot[dcmas_pkg::SCALED_W-1:0]);
        end else begin
            t_scaled = (t_quot > dcmas_pkg::NEG_LIMIT) ? dcmas_pkg::SCALED_MIN
                     : -$signed(t_quot[dcmas_pkg::SCALED_W-1:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcmas_pkg::ST_IDLE:  if (i_item_valid) n_state = dcmas_pkg::ST_UPD;
            dcmas_pkg::ST_UPD:   n_state = t_full ? dcmas_pkg::ST_AVG : dcmas_pkg::ST_IDLE;
            dcmas_pkg::ST_AVG:   if (t_div_done) n_state = dcmas_pkg::ST_SENSE;
            dcmas_pkg::ST_SENSE: n_state = dcmas_pkg::ST_DIFF;
            dcmas_pkg::ST_DIFF:  n_state = dcmas_pkg::ST_MUL;
            dcmas_pkg::ST_MUL:   n_state = dcmas_pkg::ST_MILLI;
            dcmas_pkg::ST_MILLI: if (t_div_done) n_state = dcmas_pkg::ST_OUT;
            dcmas_pkg::ST_OUT:   if (t_out_free) n_state = dcmas_pkg::ST_IDLE;
            default:             n_state = dcmas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        t_we      = 2'b00;
        t_div_req = '0;
        case (r_state)
            dcmas_pkg::ST_IDLE: begin
                o_pop = i_item_valid;
            end
            dcmas_pkg::ST_UPD: begin
                t_we[r_ch] = 1'b1;
                if (t_full) begin
                    // Quotient fits SAMPLE_BITS, so the bits above start as the remainder.
                    t_div_req.start    = 1'b1;
                    t_div_req.dividend = dcmas_pkg::DVD_W'(t_new_sum[SB-1:0])
                                         << (dcmas_pkg::DVD_W - SB);
                    t_div_req.rem_init = dcmas_pkg::DIV_W'(t_new_sum >> SB);
                    t_div_req.divisor  = dcmas_pkg::DIV_W'(WINDOW);
                    t_div_req.steps    = dcmas_pkg::AVG_STEPS;
                end
            end
            dcmas_pkg::ST_MUL: begin
                t_div_req.start    = 1'b1;
                t_div_req.dividend = dcmas_pkg::DVD_W'(t_prod);
                t_div_req.rem_init = '0;
                t_div_req.divisor  = dcmas_pkg::MILLI_DIV;
                t_div_req.steps    = dcmas_pkg::MILLI_STEPS;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dcmas_pkg::ST_IDLE: begin
                r_ch  <= i_item.ch;
                r_smp <= i_item.sample;
            end
            dcmas_pkg::ST_AVG: begin
                r_avg <= t_quot[SB-1:0];
            end
            dcmas_pkg::ST_SENSE: begin
                r_sensed <= t_sense_prod[PRD_W-1:SB];
            end
            dcmas_pkg::ST_DIFF: begin
                r_neg <= (r_sensed < t_offset);
                r_mag <= (r_sensed < t_offset) ? (t_offset - r_sensed)
                                               : (r_sensed - t_offset);
            end
            dcmas_pkg::ST_OUT: begin
                if (t_out_free) begin
                    r_o_ch     <= r_ch;
                    r_o_avg    <= r_avg;
                    r_o_sensed <= r_sensed;
                    r_o_scaled <= t_scaled;
                    r_o_led    <= r_ind;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcmas_pkg::ST_IDLE;
            r_idx[0]    <= '0;
            r_idx[1]    <= '0;
            r_filled[0] <= 1'b0;
            r_filled[1] <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_ind       <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dcmas_pkg::ST_UPD) begin
                r_sum[r_ch]    <= t_new_sum;
                r_idx[r_ch]    <= t_wrap ? '0 : r_idx[r_ch] + 1'b1;
                r_filled[r_ch] <= t_full;
            end
            if ((r_state == dcmas_pkg::ST_AVG) && t_div_done && !r_ch) begin
                r_ind <= (t_quot[SB-1:0] >= i_cfg.led_threshold);
            end
            if ((r_state == dcmas_pkg::ST_OUT) && t_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_channel      = r_o_ch;
    assign o_average_code = r_o_avg;
    assign o_sensed_uv    = r_o_sensed;
    assign o_scaled_milli = r_o_scaled;
    assign o_led_on       = r_o_led;

endmodule

`default_nettype wire

// ===== design/dual_channel_moving_average_scaler_unit.sv =====
// A full-window sample yields one result: window update, a shared-divider pass for the
// average, the sense, difference and multiply steps, a second pass for the milli-unit
// scaling, then the result register. A sample that only fills the window gets the update
// alone; the back end takes one sample at a time, up to the result register.
// Reset: synchronous, active low; clears the configuration to its defaults and all
// window state at once, with no clearing pass over the sample memories.
`default_nettype none
`include "dual_channel_moving_average_scaler_unit_assert.svh"

module dual_channel_moving_average_scaler_unit #(
    parameter int WINDOW = 200
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [dcmas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dcmas_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [dcmas_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_channel,
    output logic        [dcmas_pkg::SAMPLE_BITS-1:0]  o_average_code,
    output logic        [dcmas_pkg::SENSE_W-1:0]      o_sensed_uv,
    output logic signed [dcmas_pkg::SCALED_W-1:0]     o_scaled_milli,
    output logic                                      o_led_on
);

    dcmas_pkg::t_cfg  r_cfg;
    dcmas_pkg::t_item item;
    logic             item_valid;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dcmas_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (dcmas_pkg::t_cfg_idx'(i_cfg_index))
                dcmas_pkg::CFG_LED_THRESHOLD:
                    r_cfg.led_threshold <= i_cfg_data[dcmas_pkg::SAMPLE_BITS-1:0];
                dcmas_pkg::CFG_VOLTAGE_GAIN:
                    r_cfg.voltage_gain <= i_cfg_data[dcmas_pkg::GAIN_W-1:0];
                dcmas_pkg::CFG_VOLTAGE_OFFSET_UV:
                    r_cfg.voltage_offset_uv <= i_cfg_data[dcmas_pkg::SENSE_W-1:0];
                dcmas_pkg::CFG_CURRENT_SCALE:
                    r_cfg.current_scale <= i_cfg_data[dcmas_pkg::GAIN_W-1:0];
                dcmas_pkg::CFG_CURRENT_OFFSET_UV:
                    r_cfg.current_offset_uv <= i_cfg_data[dcmas_pkg::SENSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dcmas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    dcmas_back #(.WINDOW(WINDOW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item         (item),
        .i_item_valid   (item_valid),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_channel      (o_channel),
        .o_average_code (o_average_code),
        .o_sensed_uv    (o_sensed_uv),
        .o_scaled_milli (o_scaled_milli),
        .o_led_on       (o_led_on)
    );

    `DCMAS_ASSERT_IMP(a_pop_needs_item, i_clk, i_rst_n, pop, item_valid)
    `DCMAS_ASSERT_NXT(a_accept_is_queued, i_clk, i_rst_n, i_in_valid && o_in_ready, item_valid)
    `DCMAS_ASSERT_IMP(a_sensed_in_range, i_clk, i_rst_n, o_out_valid, o_sensed_uv <= dcmas_pkg::SENSED_MAX)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for dual_channel_moving_average_scaler_unit.
// Holds its own model of both sample windows and the scaling math.
// Depends on dcmas_pkg and the top level.
`timescale 1ns / 100ps

module testbench;

    import dcmas_pkg::*;

    localparam int unsigned WINDOW_LEN    = 200;
    localparam int unsigned SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam longint      FULL_SCALE_UV = 2500000;
    localparam longint      MILLI         = 1000;
    localparam longint      SAT_HIGH      = 16777215;
    localparam longint      SAT_LOW       = -16777216;
    localparam int unsigned OFFSET_TOP    = 2500000;
    localparam int unsigned OFFSET_WIDE   = (1 << SENSE_W) - 1;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          STALL_LIMIT   = 4000;

    typedef struct {
        logic                       ch;
        logic [SAMPLE_BITS-1:0]     avg;
        logic [SENSE_W-1:0]         sensed;
        logic signed [SCALED_W-1:0] scaled;
        logic                       led;
    } reading_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [SAMPLE_BITS-1:0]     i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic                       o_channel;
    logic [SAMPLE_BITS-1:0]     o_average_code;
    logic [SENSE_W-1:0]         o_sensed_uv;
    logic signed [SCALED_W-1:0] o_scaled_milli;
    logic                       o_led_on;

    dual_channel_moving_average_scaler_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_channel      (o_channel),
        .o_average_code (o_average_code),
        .o_sensed_uv    (o_sensed_uv),
        .o_scaled_milli (o_scaled_milli),
        .o_led_on       (o_led_on)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the block: one window per channel plus the register copies.
    logic [SAMPLE_BITS-1:0] win_store [0:1][0:WINDOW_LEN-1];
    int unsigned            win_slot [0:1];
    bit                     win_full [0:1];
    int unsigned            win_sum [0:1];
    bit                     due_ch;
    bit                     lamp;
    int unsigned            thr_code;
    int unsigned            volt_gain;
    int unsigned            volt_offset;
    int unsigned            cur_scale;
    int unsigned            cur_offset;

    reading_t pending_readings[$];
    int       failures = 0;
    int       quiet_cycles = 0;
    bit       sender_gaps = 1'b1;
    bit       receiver_stalls = 1'b1;

    function automatic void clear_model();
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_store[c][i] = '0;
            end
            win_slot[c] = 0;
            win_full[c] = 1'b0;
            win_sum[c]  = 0;
        end
        due_ch      = 1'b0;
        lamp        = 1'b0;
        thr_code    = CFG_RESET.led_threshold;
        volt_gain   = CFG_RESET.voltage_gain;
        volt_offset = CFG_RESET.voltage_offset_uv;
        cur_scale   = CFG_RESET.current_scale;
        cur_offset  = CFG_RESET.current_offset_uv;
    endfunction

    // Pushes the sample into its channel window and queues the reading it yields, if any.
    function automatic void predict_reading(input logic [SAMPLE_BITS-1:0] s);
        bit          ch;
        int unsigned slot;
        int unsigned avg;
        longint      sensed;
        longint      gain;
        longint      offset;
        longint      scaled;
        reading_t    want;
        ch   = due_ch;
        slot = win_slot[ch];
        win_sum[ch] = win_sum[ch] - win_store[ch][slot] + s;
        win_store[ch][slot] = s;
        slot++;
        if (slot == WINDOW_LEN) begin
            slot = 0;
            win_full[ch] = 1'b1;
        end
        win_slot[ch] = slot;
        due_ch = !ch;
        if (win_full[ch]) begin
            avg    = win_sum[ch] / WINDOW_LEN;
            sensed = (longint'(avg) * FULL_SCALE_UV) >>> SAMPLE_BITS;
            gain   = ch ? longint'(cur_scale) : longint'(volt_gain);
            offset = ch ? longint'(cur_offset) : longint'(volt_offset);
            // Signed division truncates toward zero, as the block does.
            scaled = gain * (sensed - offset) / MILLI;
            if (scaled > SAT_HIGH) scaled = SAT_HIGH;
            if (scaled < SAT_LOW) scaled = SAT_LOW;
            if (!ch) lamp = (avg >= thr_code);
            want.ch     = ch;
            want.avg    = avg[SAMPLE_BITS-1:0];
            want.sensed = sensed[SENSE_W-1:0];
            want.scaled = scaled[SCALED_W-1:0];
            want.led    = lamp;
            pending_readings.push_back(want);
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input int unsigned top,
                                                  input int unsigned wide_top);
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) return '0;
        if (sel == 1) return CFG_W'(top);
        if (sel == 2) return CFG_W'($urandom_range(0, wide_top));
        return CFG_W'($urandom_range(0, top));
    endfunction

    // Noisy sample around a level, with occasional full-range and extreme codes.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int level);
        int v;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return SAMPLE_BITS'(SAMPLE_MAX);
        if (sel == 2) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        v = level + int'($urandom_range(0, 600)) - 300;
        if (v < 0) v = 0;
        if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_LED_THRESHOLD:     thr_code    = value[SAMPLE_BITS-1:0];
            CFG_VOLTAGE_GAIN:      volt_gain   = value[GAIN_W-1:0];
            CFG_VOLTAGE_OFFSET_UV: volt_offset = value[SENSE_W-1:0];
            CFG_CURRENT_SCALE:     cur_scale   = value[GAIN_W-1:0];
            CFG_CURRENT_OFFSET_UV: cur_offset  = value[SENSE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] vg,
                                  input logic [CFG_W-1:0] vo, input logic [CFG_W-1:0] cs,
                                  input logic [CFG_W-1:0] co);
        write_reg(CFG_LED_THRESHOLD, thr);
        write_reg(CFG_VOLTAGE_GAIN, vg);
        write_reg(CFG_VOLTAGE_OFFSET_UV, vo);
        write_reg(CFG_CURRENT_SCALE, cs);
        write_reg(CFG_CURRENT_OFFSET_UV, co);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        if (sender_gaps && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reading(s);
    endtask

    task automatic wait_readings();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // A sample that only fills a window leaves no reading to wait for, so let it settle.
    task automatic drain_block();
        wait_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both windows fill with full-scale codes under the reset register values.
    // The wrapping sample of each window must already produce a reading.
    task automatic test_default_fill();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        for (int i = 0; i < 2 * WINDOW_LEN + 10; i++) begin
            send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        end
        drain_block();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Full gains with an oversized voltage offset force negative saturation; zeros then
    // sweep both averages from full scale to zero and turn the indicator off.
    task automatic test_extreme_regs();
        write_all_regs(CFG_W'(SAMPLE_MAX), CFG_W'(SAMPLE_MAX), CFG_W'(OFFSET_WIDE),
                       CFG_W'(SAMPLE_MAX), '0);
        for (int i = 0; i < 2 * WINDOW_LEN + 4; i++) begin
            send_sample('0);
        end
        drain_block();
        // Zero threshold keeps the indicator lit even at a zero average.
        write_all_regs('0, '0, CFG_W'(OFFSET_TOP), '0, CFG_W'(OFFSET_TOP));
        for (int i = 0; i < 8; i++) begin
            send_sample(i[0] ? SAMPLE_BITS'(SAMPLE_MAX) : '0);
        end
        drain_block();
    endtask

    task automatic test_random_phases();
        int level;
        for (int ph = 0; ph < 6; ph++) begin
            write_all_regs(pick_reg(SAMPLE_MAX, SAMPLE_MAX), pick_reg(SAMPLE_MAX, SAMPLE_MAX),
                           pick_reg(OFFSET_TOP, OFFSET_WIDE), pick_reg(SAMPLE_MAX, SAMPLE_MAX),
                           pick_reg(OFFSET_TOP, OFFSET_WIDE));
            level = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < 85; i++) begin
                if (ph == 2 && i == 40) wait_readings();
                send_sample(pick_sample(level));
            end
            drain_block();
        end
    endtask

    always @(posedge i_clk) begin
        if (receiver_stalls) begin
            i_out_ready <= ($urandom_range(0, 99) >= 20);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_field(input string name, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        failures++;
    endtask

    always @(posedge i_clk) begin : check_reading
        reading_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading, expected none, got channel %0d avg %0d",
                         $time, o_channel, o_average_code);
                failures++;
            end else begin
                want = pending_readings.pop_front();
                if (o_channel !== want.ch)
                    report_field("channel", want.ch, o_channel);
                if (o_average_code !== want.avg)
                    report_field("average_code", want.avg, o_average_code);
                if (o_sensed_uv !== want.sensed)
                    report_field("sensed_uv", want.sensed, o_sensed_uv);
                if (o_scaled_milli !== want.scaled)
                    report_field("scaled_milli", want.scaled, o_scaled_milli);
                if (o_led_on !== want.led)
                    report_field("led_on", want.led, o_led_on);
            end
        end
    end

    // Ends a hung run: counts cycles in which no handshake or register write takes place.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_fill();
        test_extreme_regs();
        test_random_phases();
        drain_block();
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
